@@ rtl/core/sva_pkg.sv @@
// Shared types and codes for the voice allocator.
// Used by every module of the block; no dependencies.
package sva_pkg;

	localparam int NOTE_W  = 7;
	localparam int VEL_W   = 7;
	localparam int VOICE_W = 3;
	localparam int STAMP_W = 32;
	localparam int MAX_OUT = 8;
	localparam int KCNT_W  = $clog2(MAX_OUT + 1);

	localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
	localparam logic [1:0] CMD_FINISHED = 2'd2;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_RETUNE  = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [NOTE_W-1:0]  note;
		logic [VEL_W-1:0]   velocity;
		logic [VOICE_W-1:0] voice_sel;
	} evt_t;

	typedef struct packed {
		logic [VOICE_W-1:0] voice;
		logic [1:0]         action;
		logic [NOTE_W-1:0]  note_res;
		logic [VEL_W-1:0]   velocity_res;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
	} held_t;

	typedef struct packed {
		logic clr;
		logic start;
		logic retune;
	} voice_wr_t;

	typedef struct packed {
		logic               active;
		logic [NOTE_W-1:0]  note;
		logic [STAMP_W-1:0] stamp;
	} voice_rd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_ON,
		ST_SCAN_OFF,
		ST_FLUSH,
		ST_RM_RD,
		ST_RM_CHK,
		ST_RM_DONE,
		ST_SH_RD,
		ST_SH_WR,
		ST_PUSH,
		ST_TOP_EMIT
	} state_t;

endpackage

@@ rtl/core/synth_voice_allocator.sv @@
// Polyphonic voice allocator, top level: mode register, sequencer,
// voice bank and held-key RAM. Depends on sva_pkg and the sva_* modules.
//
//  channel   handshake             payload
//  event     start & !busy         evt (sva_pkg::evt_t)
//  result    result_stb, 1 cycle   result (sva_pkg::res_t)
//  config    mono_we               mono_wdata
//
// Finished and unused commands never raise busy.
// Poly note on scans voices up to the first free one; note off scans every voice, then flushes.
// Mono: read and check states per held entry to remove the note; when full, read and write
// states per entry drop the oldest; the held RAM's read is registered. Results are registered.
// Reset clears all voice state at once; held RAM entries are not cleared.
// Results cannot be stalled: each strobe lasts exactly one cycle.
module synth_voice_allocator #(
	parameter int NUM_VOICES = 8,
	parameter int HELD_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sva_pkg::evt_t  evt,
	output sva_pkg::res_t  result,
	output logic           result_stb,
	input  logic           mono_we,
	input  logic           mono_wdata
);
	import sva_pkg::*;

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int AW = $clog2(HELD_DEPTH);

	logic              mono_q;
	logic [VW-1:0]     rd_idx, wr_idx;
	logic [NOTE_W-1:0] wr_note;
	voice_wr_t         vwr;
	voice_rd_t         vrd, v0;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	held_t             ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q <= 1'b0;
		end else if (mono_we) begin
			mono_q <= mono_wdata;
		end
	end

	sva_seq #(
		.NUM_VOICES(NUM_VOICES),
		.HELD_DEPTH(HELD_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.evt        (evt),
		.mono       (mono_q),
		.held_clr   (mono_we),
		.result     (result),
		.result_stb (result_stb),
		.rd_idx     (rd_idx),
		.vwr        (vwr),
		.wr_idx     (wr_idx),
		.wr_note    (wr_note),
		.vrd        (vrd),
		.v0         (v0),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	sva_voice_bank #(
		.NUM_VOICES(NUM_VOICES)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.wr      (vwr),
		.wr_idx  (wr_idx),
		.wr_note (wr_note),
		.rd      (vrd),
		.v0      (v0)
	);

	sva_held_ram #(
		.HELD_DEPTH(HELD_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	a_note_on_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (evt.cmd == CMD_NOTE_ON) |=> busy)
		else $error("note on beat did not start a sequence");

	a_quick_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((evt.cmd == CMD_FINISHED) || (evt.cmd == CMD_UNUSED)) |=> !busy)
		else $error("finished or unused beat raised busy");

	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && !result.last |-> busy)
		else $error("non-final result while sequencer idle");
`endif

endmodule

@@ rtl/core/sva_held_ram.sv @@
// Held-key stack storage: one write port, one registered read port.
// Depends on sva_pkg for the entry type.
module sva_held_ram #(
	parameter int HELD_DEPTH = 16,
	localparam int AW = $clog2(HELD_DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  sva_pkg::held_t   wdata,
	input  logic [AW-1:0]    raddr,
	output sva_pkg::held_t   rdata
);
	import sva_pkg::*;

	held_t mem [HELD_DEPTH];
	held_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/sva_voice_bank.sv @@
// Per-voice state: active flag, note, start stamp, and the stamp counter.
// One scan read port plus a fixed voice-zero view. Depends on sva_pkg.
module sva_voice_bank #(
	parameter int NUM_VOICES = 8,
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [VW-1:0]              rd_idx,
	input  sva_pkg::voice_wr_t         wr,
	input  logic [VW-1:0]              wr_idx,
	input  logic [sva_pkg::NOTE_W-1:0] wr_note,
	output sva_pkg::voice_rd_t         rd,
	output sva_pkg::voice_rd_t         v0
);
	import sva_pkg::*;

	logic               active_q [NUM_VOICES];
	logic [NOTE_W-1:0]  note_q   [NUM_VOICES];
	logic [STAMP_W-1:0] stamp_q  [NUM_VOICES];
	logic [STAMP_W-1:0] counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				active_q[i] <= 1'b0;
				note_q[i]   <= '0;
				stamp_q[i]  <= '0;
			end
			counter_q <= '0;
		end else begin
			if (wr.clr) begin
				active_q[wr_idx] <= 1'b0;
			end
			if (wr.start) begin
				active_q[wr_idx] <= 1'b1;
				note_q[wr_idx]   <= wr_note;
				stamp_q[wr_idx]  <= counter_q;
				counter_q        <= counter_q + 1'b1;
			end
			if (wr.retune) begin
				note_q[0] <= wr_note;
			end
		end
	end

	assign rd.active = active_q[rd_idx];
	assign rd.note   = note_q[rd_idx];
	assign rd.stamp  = stamp_q[rd_idx];
	assign v0.active = active_q[0];
	assign v0.note   = note_q[0];
	assign v0.stamp  = stamp_q[0];

endmodule

@@ rtl/core/sva_seq.sv @@
// Event sequencer: voice scans with one stamp comparator, held-stack
// remove/shift/push sweeps, and the result register. Depends on sva_pkg.
module sva_seq #(
	parameter int NUM_VOICES = 8,
	parameter int HELD_DEPTH = 16,
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
	localparam int AW = $clog2(HELD_DEPTH),
	localparam int CW = $clog2(HELD_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  sva_pkg::evt_t              evt,
	input  logic                       mono,
	input  logic                       held_clr,
	output sva_pkg::res_t              result,
	output logic                       result_stb,
	output logic [VW-1:0]              rd_idx,
	output sva_pkg::voice_wr_t         vwr,
	output logic [VW-1:0]              wr_idx,
	output logic [sva_pkg::NOTE_W-1:0] wr_note,
	input  sva_pkg::voice_rd_t         vrd,
	input  sva_pkg::voice_rd_t         v0,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr,
	output sva_pkg::held_t             ram_wdata,
	output logic [AW-1:0]              ram_raddr,
	input  sva_pkg::held_t             ram_rdata
);
	import sva_pkg::*;

	state_t             state_q, state_d;
	evt_t               op_q;
	logic [VW-1:0]      v_q, oldest_q, pend_v_q;
	logic [STAMP_W-1:0] oldest_stamp_q;
	logic [KCNT_W-1:0]  k_q;
	logic               pend_q;
	logic [CW-1:0]      r_q, w_q, count_q;
	res_t               res_q, emit_res;
	logic               stb_q, emit;

	logic          accept, last_v, older, hit, keep, r_end, full, shift_end, v0_match;
	logic [CW-1:0] r_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign last_v    = (v_q == VW'(NUM_VOICES - 1));
	assign older     = (vrd.stamp < oldest_stamp_q);
	assign hit       = vrd.active && (vrd.note == op_q.note) && (k_q < KCNT_W'(MAX_OUT));
	assign keep      = (ram_rdata.note != op_q.note);
	assign r_inc     = r_q + 1'b1;
	assign r_end     = (r_inc == count_q);
	assign full      = (count_q == CW'(HELD_DEPTH));
	assign shift_end = (r_q == CW'(HELD_DEPTH - 1));
	assign v0_match  = v0.active && (v0.note == op_q.note);

	assign busy       = (state_q != ST_IDLE);
	assign rd_idx     = v_q;
	assign result     = res_q;
	assign result_stb = stb_q;
	assign ram_raddr  = (state_q == ST_RM_DONE) ? AW'(count_q - 1'b1) : r_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (evt.cmd)
						CMD_NOTE_ON, CMD_NOTE_OFF: begin
							if (mono) begin
								state_d = (count_q == '0) ? ST_RM_DONE : ST_RM_RD;
							end else begin
								state_d = (evt.cmd == CMD_NOTE_ON) ? ST_SCAN_ON : ST_SCAN_OFF;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN_ON: if (!vrd.active || last_v) state_d = ST_IDLE;
			ST_SCAN_OFF: if (last_v) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			ST_RM_RD: state_d = ST_RM_CHK;
			ST_RM_CHK: state_d = r_end ? ST_RM_DONE : ST_RM_RD;
			ST_RM_DONE: begin
				if (op_q.cmd == CMD_NOTE_ON) begin
					state_d = full ? ST_SH_RD : ST_PUSH;
				end else begin
					state_d = (v0_match && (count_q != '0)) ? ST_TOP_EMIT : ST_IDLE;
				end
			end
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: state_d = shift_end ? ST_PUSH : ST_SH_RD;
			ST_PUSH: state_d = ST_IDLE;
			ST_TOP_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_res  = '0;
		vwr       = '0;
		wr_idx    = v_q;
		wr_note   = op_q.note;
		ram_we    = 1'b0;
		ram_waddr = w_q[AW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			ST_IDLE: begin
				if (accept && (evt.cmd == CMD_FINISHED) && (int'(evt.voice_sel) < NUM_VOICES)) begin
					vwr.clr = 1'b1;
					wr_idx  = VW'(evt.voice_sel);
				end
			end
			ST_SCAN_ON: begin
				if (!vrd.active || last_v) begin
					vwr.start = 1'b1;
					wr_idx    = (!vrd.active || older) ? v_q : oldest_q;
					emit      = 1'b1;
					emit_res  = '{voice: VOICE_W'(wr_idx), action: ACT_START,
						note_res: op_q.note, velocity_res: op_q.velocity, last: 1'b1};
				end
			end
			ST_SCAN_OFF: begin
				if (hit && pend_q) begin
					emit     = 1'b1;
					emit_res = '{voice: VOICE_W'(pend_v_q), action: ACT_RELEASE,
						note_res: op_q.note, velocity_res: '0, last: 1'b0};
				end
			end
			ST_FLUSH: begin
				if (pend_q) begin
					emit     = 1'b1;
					emit_res = '{voice: VOICE_W'(pend_v_q), action: ACT_RELEASE,
						note_res: op_q.note, velocity_res: '0, last: 1'b1};
				end
			end
			ST_RM_CHK: begin
				ram_we = keep;
			end
			ST_RM_DONE: begin
				if ((op_q.cmd == CMD_NOTE_OFF) && v0_match && (count_q == '0)) begin
					emit     = 1'b1;
					emit_res = '{voice: '0, action: ACT_RELEASE,
						note_res: op_q.note, velocity_res: '0, last: 1'b1};
				end
			end
			ST_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(r_q - 1'b1);
			end
			ST_PUSH: begin
				ram_we     = 1'b1;
				ram_waddr  = count_q[AW-1:0];
				ram_wdata  = '{note: op_q.note, velocity: op_q.velocity};
				wr_idx     = '0;
				vwr.retune = v0.active;
				vwr.start  = !v0.active;
				emit       = 1'b1;
				emit_res   = '{voice: '0, action: v0.active ? ACT_RETUNE : ACT_START,
					note_res: op_q.note, velocity_res: op_q.velocity, last: 1'b1};
			end
			ST_TOP_EMIT: begin
				vwr.retune = 1'b1;
				wr_note    = ram_rdata.note;
				emit       = 1'b1;
				emit_res   = '{voice: '0, action: ACT_RETUNE,
					note_res: ram_rdata.note, velocity_res: ram_rdata.velocity, last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			k_q     <= '0;
			stb_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			stb_q   <= emit;
			if (held_clr) begin
				count_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q    <= '0;
						pend_q <= 1'b0;
					end
				end
				ST_SCAN_OFF: begin
					if (hit) begin
						pend_q <= 1'b1;
						k_q    <= k_q + 1'b1;
					end
				end
				ST_FLUSH: pend_q <= 1'b0;
				ST_RM_CHK: begin
					if (r_end) begin
						count_q <= w_q + CW'(keep);
					end
				end
				ST_SH_WR: begin
					if (shift_end) begin
						count_q <= CW'(HELD_DEPTH - 1);
					end
				end
				ST_PUSH: count_q <= count_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q           <= evt;
					v_q            <= '0;
					oldest_q       <= '0;
					oldest_stamp_q <= v0.stamp;
					r_q            <= '0;
					w_q            <= '0;
				end
			end
			ST_SCAN_ON: begin
				if (older) begin
					oldest_q       <= v_q;
					oldest_stamp_q <= vrd.stamp;
				end
				v_q <= VW'(v_q + 1'b1);
			end
			ST_SCAN_OFF: begin
				if (hit) begin
					pend_v_q <= v_q;
				end
				v_q <= VW'(v_q + 1'b1);
			end
			ST_RM_CHK: begin
				if (keep) begin
					w_q <= w_q + 1'b1;
				end
				r_q <= r_inc;
			end
			ST_RM_DONE: r_q <= CW'(1);
			ST_SH_WR: begin
				if (!shift_end) begin
					r_q <= r_inc;
				end
			end
			default: ;
		endcase
	end

endmodule
